// ===== design/mhpq_pkg.sv =====
// Shared constants, codes and controller/datapath link types for the heap queue.
`default_nettype none

package mhpq_pkg;

	localparam int DEF_CAPACITY = 1024;
	localparam int DATA_W       = 32;
	localparam int STATUS_W     = 2;
	localparam int COUNT_W      = 11;

	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic start;      // request transaction accepted
		logic rd_ends;    // read root and last entry
		logic load_ends;  // capture root as result, last entry as element
		logic rd_parent;  // read parent of hole
		logic rd_kids;    // read both children of hole
		logic wr_elem;    // park element in hole
		logic move_up;    // parent drops into hole, hole moves up
		logic move_down;  // larger child rises into hole, hole moves down
		logic out_load;   // load response register
	} mhpq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic op;
		logic full;
		logic empty;
		logic pos_zero;
		logic leaf;
		logic up_go;
		logic dn_stop;
		logic out_busy;
	} mhpq_sts_t;

endpackage

`default_nettype wire

// ===== design/mhpq_if.sv =====
// Request and response channel interfaces of the heap queue.
`default_nettype none

interface mhpq_req_if import mhpq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     operation;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

interface mhpq_rsp_if import mhpq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] result_value;
	logic [STATUS_W-1:0]      status;
	logic [COUNT_W-1:0]       count;

	modport source (output valid, output result_value, output status, output count,
		input ready);
	modport sink   (input valid, input result_value, input status, input count,
		output ready);
endinterface

`default_nettype wire

// ===== design/mhpq_ctrl.sv =====
// Sequencing state machine for insert (sift-up) and extract (sift-down).
`default_nettype none

module mhpq_ctrl import mhpq_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire mhpq_sts_t sts,
	output mhpq_cmd_t      cmd
);

	typedef enum logic [2:0] {
		IDLE,
		EX_LD,
		UP_CHK,
		UP_CMP,
		DN_CHK,
		DN_CMP,
		FIN
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			IDLE: begin
				if (req_valid) begin
					cmd.start = 1'b1;
					if (sts.op == OP_INSERT) begin
						state_d = sts.full ? FIN : UP_CHK;
					end else if (sts.empty) begin
						state_d = FIN;
					end else begin
						cmd.rd_ends = 1'b1;
						state_d     = EX_LD;
					end
				end
			end
			EX_LD: begin
				cmd.load_ends = 1'b1;
				state_d       = DN_CHK;
			end
			UP_CHK: begin
				if (sts.pos_zero) begin
					cmd.wr_elem = 1'b1;
					state_d     = FIN;
				end else begin
					cmd.rd_parent = 1'b1;
					state_d       = UP_CMP;
				end
			end
			UP_CMP: begin
				if (sts.up_go) begin
					cmd.move_up = 1'b1;
					state_d     = UP_CHK;
				end else begin
					cmd.wr_elem = 1'b1;
					state_d     = FIN;
				end
			end
			DN_CHK: begin
				if (sts.leaf) begin
					cmd.wr_elem = 1'b1;
					state_d     = FIN;
				end else begin
					cmd.rd_kids = 1'b1;
					state_d     = DN_CMP;
				end
			end
			DN_CMP: begin
				if (sts.dn_stop) begin
					cmd.wr_elem = 1'b1;
					state_d     = FIN;
				end else begin
					cmd.move_down = 1'b1;
					state_d       = DN_CHK;
				end
			end
			FIN: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = IDLE;
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/mhpq_dp.sv =====
// Heap store, hole pointer, element and response registers of the heap queue.
`default_nettype none

module mhpq_dp import mhpq_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     req_operation,
	input  wire logic signed [DATA_W-1:0] req_value,
	input  wire logic                     rsp_ready,
	output logic                          rsp_valid,
	output logic signed [DATA_W-1:0]      rsp_result_value,
	output logic [STATUS_W-1:0]           rsp_status,
	output logic [COUNT_W-1:0]            rsp_count,
	input  wire mhpq_cmd_t                cmd,
	output mhpq_sts_t                     sts
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = AW + 2;

	logic signed [DATA_W-1:0] mem [CAPACITY];

	logic [CW-1:0]            count_q;
	logic [AW-1:0]            pos_q;
	logic signed [DATA_W-1:0] elem_q;
	logic signed [DATA_W-1:0] result_q;
	logic [STATUS_W-1:0]      st_q;
	logic signed [DATA_W-1:0] rd_a_q, rd_b_q;
	logic                     out_valid_q;

	logic [AW-1:0]            parent, last;
	logic [LW-1:0]            left, right, count_x;
	logic                     has_right, pick_right;
	logic                     full, empty;
	logic [AW-1:0]            rd_a_addr, rd_b_addr, wr_addr;
	logic signed [DATA_W-1:0] wr_data;
	logic                     wr_en;

	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign parent    = (pos_q - AW'(1)) >> 1;
	assign last      = AW'(count_q - CW'(1));
	assign left      = LW'({pos_q, 1'b1});
	assign right     = left + LW'(1);
	assign count_x   = LW'(count_q);
	assign has_right = (right < count_x);
	assign pick_right = has_right && (rd_a_q < rd_b_q);

	assign sts.op       = req_operation;
	assign sts.full     = full;
	assign sts.empty    = empty;
	assign sts.pos_zero = (pos_q == '0);
	assign sts.leaf     = (left >= count_x);
	assign sts.up_go    = (elem_q > rd_a_q);
	assign sts.dn_stop  = has_right ? ((elem_q > rd_a_q) && (elem_q > rd_b_q))
	                                : (elem_q > rd_a_q);
	assign sts.out_busy = out_valid_q && !rsp_ready;

	// read address muxing
	always_comb begin
		rd_a_addr = parent;
		rd_b_addr = right[AW-1:0];
		if (cmd.rd_ends) begin
			rd_a_addr = '0;
			rd_b_addr = last;
		end else if (cmd.rd_kids) begin
			rd_a_addr = left[AW-1:0];
		end
	end

	// single write port: hole at pos_q takes element, parent or chosen child
	always_comb begin
		wr_addr = pos_q;
		wr_en   = cmd.wr_elem || cmd.move_up || cmd.move_down;
		wr_data = elem_q;
		if (cmd.move_up) begin
			wr_data = rd_a_q;
		end else if (cmd.move_down) begin
			wr_data = pick_right ? rd_b_q : rd_a_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_ends || cmd.rd_kids || cmd.rd_parent) begin
			rd_a_q <= mem[rd_a_addr];
		end
		if (cmd.rd_ends || cmd.rd_kids) begin
			rd_b_q <= mem[rd_b_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			result_q <= '0;
			elem_q   <= req_value;
			pos_q    <= count_q[AW-1:0];
			if (req_operation == OP_INSERT) begin
				st_q <= full ? ST_FULL : ST_DONE;
			end else begin
				st_q <= empty ? ST_EMPTY : ST_DONE;
			end
		end else if (cmd.load_ends) begin
			result_q <= rd_a_q;
			elem_q   <= rd_b_q;
			pos_q    <= '0;
		end else if (cmd.move_up) begin
			pos_q <= parent;
		end else if (cmd.move_down) begin
			pos_q <= pick_right ? right[AW-1:0] : left[AW-1:0];
		end
		if (cmd.out_load) begin
			rsp_result_value <= result_q;
			rsp_status       <= st_q;
			rsp_count        <= COUNT_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				if (req_operation == OP_INSERT && !full) begin
					count_q <= count_q + CW'(1);
				end else if (req_operation == OP_EXTRACT && !empty) begin
					count_q <= count_q - CW'(1);
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== design/max_heap_priority_queue.sv =====
// Insert sifts the new entry up from the hole at the end, extract sifts the last entry
// down from the root, and a dropped insert or an empty extract goes straight to the
// response register; the entry moves at most log2(CAPACITY) levels.
// One transaction at a time: a new request is accepted only when idle, and each
// level costs one read-then-compare pair on the heap store.
// Reset clears the count and control state; store entries are written before any read.
`default_nettype none

module max_heap_priority_queue import mhpq_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mhpq_req_if.sink    req,
	mhpq_rsp_if.source  rsp
);

	mhpq_cmd_t cmd;
	mhpq_sts_t sts;

	mhpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mhpq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_operation    (req.operation),
		.req_value        (req.value),
		.rsp_ready        (rsp.ready),
		.rsp_valid        (rsp.valid),
		.rsp_result_value (rsp.result_value),
		.rsp_status       (rsp.status),
		.rsp_count        (rsp.count),
		.cmd              (cmd),
		.sts              (sts)
	);

endmodule

`default_nettype wire

// ===== design/mhpq_checker.sv =====
// Port-level checks for the heap queue and their bind to the top level.
`default_nettype none

module mhpq_checker import mhpq_pkg::*; (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     rsp_valid,
	input wire logic                     rsp_ready,
	input wire logic signed [DATA_W-1:0] rsp_result_value,
	input wire logic [STATUS_W-1:0]      rsp_status,
	input wire logic [COUNT_W-1:0]       rsp_count
);

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
			&& $stable(rsp_status) && $stable(rsp_count))
		else $error("response changed while stalled");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_result_value == '0)
		else $error("dropped insert returned a value");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |-> rsp_result_value == '0 && rsp_count == '0)
		else $error("empty extract returned data or nonzero count");

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_result_value (rsp.result_value),
	.rsp_status       (rsp.status),
	.rsp_count        (rsp.count)
);

`default_nettype wire
